// ===== rtl/catm_pkg.sv =====
// ----------------------------------------------------------------------------
// catm_pkg
// Shared types and codes for the calendar alarm table: entry and tick
// records, item modes and result kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package catm_pkg;

   localparam int SCAN_HIT_LIMIT = 16;
   localparam int RES_CNT_W      = 5;

   localparam logic [1:0] ACT_SCRIPT = 2'd3;
   localparam logic [2:0] PAT_MAX    = 3'd5;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_TICK  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      RK_LOADED  = 3'd0,
      RK_INVALID = 3'd1,
      RK_FULL    = 3'd2,
      RK_CLEARED = 3'd3,
      RK_MATCH   = 3'd4,
      RK_NOMATCH = 3'd5
   } result_type;

   typedef struct packed {
      logic [11:0] months;
      logic [6:0]  days;
      logic [23:0] hours;
      logic [5:0]  minute;
      logic [1:0]  kind;
      logic [2:0]  pat;
      logic [7:0]  pick;
   } entry_type;

   typedef struct packed {
      logic [3:0] month;
      logic [2:0] weekday;
      logic [4:0] hour;
      logic [5:0] minute;
   } tick_type;

endpackage

`default_nettype wire

// ===== rtl/catm_cell.sv =====
// ----------------------------------------------------------------------------
// catm_cell
// One table slot of the rotating entry chain: takes a new entry on load,
// otherwise takes its neighbour's entry when the chain rotates.
// ----------------------------------------------------------------------------
`default_nettype none

module catm_cell (
   input  logic                clock,
   input  logic                load_en,
   input  catm_pkg::entry_type load_data,
   input  logic                shift_en,
   input  catm_pkg::entry_type shift_data,
   output catm_pkg::entry_type entry_out
);
   import catm_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load_en) begin
         entry_in = load_data;
      end else if (shift_en) begin
         entry_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

`default_nettype wire

// ===== rtl/catm_match.sv =====
// ----------------------------------------------------------------------------
// catm_match
// Compares the entry at the head of the chain against the current tick.
// ----------------------------------------------------------------------------
`default_nettype none

module catm_match (
   input  catm_pkg::entry_type entry,
   input  catm_pkg::tick_type  tick,
   output logic                hit
);
   import catm_pkg::*;

   logic month_ok;
   logic day_ok;
   logic hour_ok;
   logic minute_ok;

   // out-of-range tick fields select no bit
   always_comb begin
      month_ok  = 1'b0;
      day_ok    = 1'b0;
      hour_ok   = 1'b0;
      if (tick.month < 4'd12) begin
         month_ok = entry.months[tick.month];
      end
      if (tick.weekday < 3'd7) begin
         day_ok = entry.days[tick.weekday];
      end
      if (tick.hour < 5'd24) begin
         hour_ok = entry.hours[tick.hour];
      end
      minute_ok = (entry.minute < 6'd60) && (entry.minute == tick.minute);
   end

   assign hit = month_ok && day_ok && hour_ok && minute_ok;

endmodule

`default_nettype wire

// ===== rtl/calendar_alarm_table_match.sv =====
// ----------------------------------------------------------------------------
// calendar_alarm_table_match
// Clear and load items: the result is registered at the accepting edge.
// Tick items: the entry chain rotates one cell a cycle past a single matcher
// unless a second match waits for the output register; a full turn restores order.
// A tick holds req_ready low until its final result is registered.
// Reset empties the table count and drops any scan; entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_alarm_table_match #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [1:0]  req_entry_kind,
   input  logic [11:0] req_month_set,
   input  logic [6:0]  req_day_set,
   input  logic [23:0] req_hour_set,
   input  logic [5:0]  req_entry_minute,
   input  logic [2:0]  req_pattern_kind,
   input  logic [7:0]  req_pick_count,
   input  logic [3:0]  req_now_month,
   input  logic [2:0]  req_now_weekday,
   input  logic [4:0]  req_now_hour,
   input  logic [5:0]  req_now_minute,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_result_kind,
   output logic [3:0]  rsp_entry_index,
   output logic [1:0]  rsp_action_kind,
   output logic [2:0]  rsp_match_pattern_kind,
   output logic [7:0]  rsp_match_pick_count,
   output logic        rsp_last
);
   import catm_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int EXT_W = CNT_W + 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      step_ff, step_in;
   logic [RES_CNT_W-1:0]  nres_ff, nres_in;
   logic                  stop_ff, stop_in;
   tick_type              tick_ff, tick_in;

   logic                  pend_v_ff, pend_v_in;
   logic [3:0]            pend_idx_ff, pend_idx_in;
   entry_type             pend_ff, pend_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_kind_ff, rsp_kind_in;
   logic [3:0]            rsp_idx_ff, rsp_idx_in;
   logic [1:0]            rsp_act_ff, rsp_act_in;
   logic [2:0]            rsp_pat_ff, rsp_pat_in;
   logic [7:0]            rsp_pick_ff, rsp_pick_in;
   logic                  rsp_last_ff, rsp_last_in;

   entry_type             chain [TABLE_DEPTH];
   entry_type             new_entry;
   logic                  load_we;
   logic                  shift_en;
   logic                  head_hit;
   logic                  hit;
   logic                  out_free;
   logic                  req_fire;
   logic                  load_bad;
   logic [EXT_W-1:0]      count_ext;
   logic [EXT_W-1:0]      step_ext;

   // ---- entry chain: cell 0 is the head, the head wraps to the tail ----
   assign new_entry = '{months: req_month_set, days: req_day_set, hours: req_hour_set,
                        minute: req_entry_minute, kind: req_entry_kind,
                        pat: req_pattern_kind, pick: req_pick_count};

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      catm_cell u_cell (
         .clock      (clock),
         .load_en    (load_we && (count_ff == CNT_W'(i))),
         .load_data  (new_entry),
         .shift_en   (shift_en),
         .shift_data (chain[(i + 1) % TABLE_DEPTH]),
         .entry_out  (chain[i])
      );
   end

   catm_match u_match (
      .entry (chain[0]),
      .tick  (tick_ff),
      .hit   (head_hit)
   );

   // ---- control ----
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign count_ext = EXT_W'(count_ff);
   assign step_ext  = EXT_W'(step_ff);
   assign hit       = (state_ff == ST_SCAN) && (step_ff < count_ff) && !stop_ff && head_hit;
   assign load_bad  = (req_month_set == '0) || (req_day_set == '0) || (req_hour_set == '0)
                   || (req_pattern_kind == '0) || (req_pattern_kind > PAT_MAX);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      nres_in      = nres_ff;
      stop_in      = stop_ff;
      tick_in      = tick_ff;
      pend_v_in    = pend_v_ff;
      pend_idx_in  = pend_idx_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_pat_in   = rsp_pat_ff;
      rsp_pick_in  = rsp_pick_ff;
      rsp_last_in  = rsp_last_ff;
      load_we      = 1'b0;
      shift_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_mode)
                  MODE_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = RK_CLEARED;
                     rsp_idx_in   = '0;
                     rsp_act_in   = '0;
                     rsp_pat_in   = '0;
                     rsp_pick_in  = '0;
                     rsp_last_in  = 1'b1;
                  end
                  MODE_LOAD: begin
                     rsp_valid_in = 1'b1;
                     rsp_idx_in   = '0;
                     rsp_act_in   = '0;
                     rsp_pat_in   = '0;
                     rsp_pick_in  = '0;
                     rsp_last_in  = 1'b1;
                     if (load_bad) begin
                        rsp_kind_in = RK_INVALID;
                     end else if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        rsp_kind_in = RK_FULL;
                     end else begin
                        load_we     = 1'b1;
                        count_in    = count_ff + 1'b1;
                        rsp_kind_in = RK_LOADED;
                        rsp_idx_in  = count_ext[3:0];
                     end
                  end
                  MODE_TICK: begin
                     tick_in   = '{month: req_now_month, weekday: req_now_weekday,
                                   hour: req_now_hour, minute: req_now_minute};
                     step_in   = '0;
                     nres_in   = '0;
                     stop_in   = 1'b0;
                     pend_v_in = 1'b0;
                     state_in  = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // hold the chain while a second match waits for the output register
            if (!(hit && pend_v_ff && !out_free)) begin
               shift_en = 1'b1;
               step_in  = step_ff + 1'b1;
               if (hit) begin
                  if (pend_v_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = RK_MATCH;
                     rsp_idx_in   = pend_idx_ff;
                     rsp_act_in   = pend_ff.kind;
                     rsp_pat_in   = pend_ff.pat;
                     rsp_pick_in  = pend_ff.pick;
                     rsp_last_in  = 1'b0;
                  end
                  pend_v_in   = 1'b1;
                  pend_in     = chain[0];
                  pend_idx_in = step_ext[3:0];
                  nres_in     = nres_ff + 1'b1;
                  if ((chain[0].kind == ACT_SCRIPT)
                      || (nres_ff == RES_CNT_W'(SCAN_HIT_LIMIT - 1))) begin
                     stop_in = 1'b1;
                  end
               end
               if (step_ff == CNT_W'(TABLE_DEPTH - 1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (pend_v_ff) begin
                  rsp_kind_in = RK_MATCH;
                  rsp_idx_in  = pend_idx_ff;
                  rsp_act_in  = pend_ff.kind;
                  rsp_pat_in  = pend_ff.pat;
                  rsp_pick_in = pend_ff.pick;
               end else begin
                  rsp_kind_in = RK_NOMATCH;
                  rsp_idx_in  = '0;
                  rsp_act_in  = '0;
                  rsp_pat_in  = '0;
                  rsp_pick_in = '0;
               end
               pend_v_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tick_ff     <= tick_in;
      pend_idx_ff <= pend_idx_in;
      pend_ff     <= pend_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_pat_ff  <= rsp_pat_in;
      rsp_pick_ff <= rsp_pick_in;
      rsp_last_ff <= rsp_last_in;
      step_ff     <= step_in;
      nres_ff     <= nres_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         stop_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         stop_ff      <= stop_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_kind        = rsp_kind_ff;
   assign rsp_entry_index        = rsp_idx_ff;
   assign rsp_action_kind        = rsp_act_ff;
   assign rsp_match_pattern_kind = rsp_pat_ff;
   assign rsp_match_pick_count   = rsp_pick_ff;
   assign rsp_last               = rsp_last_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_full_turn: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> step_ff == CNT_W'(TABLE_DEPTH))
      else $error("scan finished without a full chain rotation");

   a_res_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> nres_ff <= RES_CNT_W'(SCAN_HIT_LIMIT))
      else $error("too many matches in one tick");

   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_v_ff)
      else $error("pending match left behind after a scan");
`endif

endmodule

`default_nettype wire
